### sv/sslim_pkg.sv
// ----------------------------------------------------------------------------
// sslim_pkg
// Shared types, constants and helpers for the servo slew limiter.
// ----------------------------------------------------------------------------
package sslim_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam int POS_W   = 14;
    localparam int STEP_W  = 8;
    localparam int PROM_W  = 16;
    localparam int FUNC_W  = 3;
    localparam int CH_W    = 3;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [CH_W-1:0]   t_ch;

    // request function codes
    localparam t_func FUNC_TICK = 3'd0;
    localparam t_func FUNC_SET  = 3'd1;
    localparam t_func FUNC_POS  = 3'd2;
    localparam t_func FUNC_STEP = 3'd3;
    localparam t_func FUNC_TEST = 3'd4;

    // result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ACK    = 1'b1;

    localparam t_pos HOME_COUNT  = 14'd6000;
    localparam t_pos SWEEP_HIGH  = 14'd8000;
    localparam t_pos SWEEP_LOW   = 14'd4000;
    localparam t_pos SWEEP_DELTA = 14'd10;

    localparam logic signed [PROM_W-1:0] PROM_MIN = -16'sd2500;
    localparam logic signed [PROM_W-1:0] PROM_MAX = 16'sd1900;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_CMD
    } t_state;

    // operands of the shared slew unit
    typedef struct packed {
        t_pos  cur;
        t_pos  tgt;
        t_step step;
    } t_slew_req;

    // promille -> timer counts: clamp, double, add home
    function automatic t_pos to_counts(input logic signed [PROM_W-1:0] p);
        logic signed [PROM_W-1:0] c;
        logic signed [PROM_W-1:0] v;
        if (p < PROM_MIN) begin
            c = PROM_MIN;
        end else if (p > PROM_MAX) begin
            c = PROM_MAX;
        end else begin
            c = p;
        end
        v = (c <<< 1) + 16'sd6000;
        return v[POS_W-1:0];
    endfunction

endpackage

### sv/sslim_if.sv
// ----------------------------------------------------------------------------
// sslim_if
// Request and result channels of the servo slew limiter.
// ----------------------------------------------------------------------------
interface sslim_req_if;
    import sslim_pkg::*;

    logic                     valid;
    logic                     ready;
    t_func                    func;
    t_ch                      channel;
    logic signed [PROM_W-1:0] position_promille;
    t_step                    speed;

    modport source (output valid, func, channel, position_promille, speed, input ready);
    modport sink   (input valid, func, channel, position_promille, speed, output ready);
endinterface

interface sslim_rsp_if;
    import sslim_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    t_ch  out_channel;
    t_pos position;
    logic last;

    modport source (output valid, kind, out_channel, position, last, input ready);
    modport sink   (input valid, kind, out_channel, position, last, output ready);
endinterface

### sv/sslim_slew_unit.sv
// ----------------------------------------------------------------------------
// sslim_slew_unit
// Shared slew step: moves one position toward its target by one step.
// ----------------------------------------------------------------------------
module sslim_slew_unit (
    input  sslim_pkg::t_slew_req i_req,
    output sslim_pkg::t_pos      o_next
);
    import sslim_pkg::*;

    logic up;
    t_pos gap;
    t_pos step_ext;

    assign up       = i_req.tgt > i_req.cur;
    assign gap      = up ? (i_req.tgt - i_req.cur) : (i_req.cur - i_req.tgt);
    assign step_ext = POS_W'(i_req.step);

    always_comb begin
        if (i_req.cur == i_req.tgt || i_req.step == '0) begin
            o_next = i_req.cur;
        end else if (gap <= step_ext) begin
            o_next = i_req.tgt;
        end else if (up) begin
            o_next = i_req.cur + step_ext;
        end else begin
            o_next = i_req.cur - step_ext;
        end
    end

endmodule

### sv/eight_channel_servo_slew_limiter_unit.sv
// ----------------------------------------------------------------------------
// eight_channel_servo_slew_limiter_unit
// Per-channel servo position slew limiter with test sweep and command port.
// ----------------------------------------------------------------------------
//  channel  | dir | contents                                       | per request
//  ---------+-----+------------------------------------------------+------------
//  i_req    | in  | func, channel, position_promille, speed        | one
//  o_rsp    | out | kind, out_channel, position, last              | 0, 1 or N
//
//  A tick latches the request, then walks every channel in turn through the
//  single shared slew unit, which reads and writes one channel a cycle unless
//  the output stalls. A command latches, then updates and acknowledges.
//  Output stalls hold the sequencer; the output register lets a new request in
//  while the final result still waits. Reset is synchronous and restores all
//  channels to home (6000 counts), zero steps, test sweep off.
// ----------------------------------------------------------------------------
module eight_channel_servo_slew_limiter_unit #(
    parameter int CHANNELS = sslim_pkg::CHANNELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sslim_req_if.sink    i_req,
    sslim_rsp_if.source  o_rsp
);
    import sslim_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // channel state
    t_pos  r_cur  [CHANNELS];
    t_pos  r_tgt  [CHANNELS];
    t_step r_step [CHANNELS];

    // test sweep
    logic  r_test;
    t_pos  r_sweep_level;
    logic  r_sweep_rising;
    logic  n_sweep_rising;
    t_pos  n_sweep_level;

    // latched request
    t_func                    r_func;
    t_ch                      r_ch;
    logic signed [PROM_W-1:0] r_prom;
    t_step                    r_speed;
    logic                     r_tick_test;   // tick overrides positions with sweep
    t_pos                     r_sweep_snap;  // sweep level seen by this tick

    // sequencer
    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_idx;

    // output register
    logic r_out_valid;
    logic r_kind;
    t_ch  r_out_ch;
    t_pos r_out_pos;
    logic r_last;

    // control
    logic accept;
    logic slot_free;
    logic do_tick;
    logic do_cmd;
    logic tick_last;
    logic req_ready;

    assign accept    = i_req.valid && req_ready;
    assign slot_free = !r_out_valid || o_rsp.ready;

    // -------------------------------------------------------------------------
    // Single read port into the channel state: tick walks r_idx, commands use
    // the addressed channel.
    // -------------------------------------------------------------------------
    logic [CW-1:0] cidx;
    logic [CW-1:0] rd_idx;
    logic          ch_ok;
    t_pos          rd_cur;
    t_pos          rd_tgt;
    t_step         rd_step;

    assign cidx    = CW'(r_ch);
    assign ch_ok   = 32'(r_ch) < CHANNELS;
    assign rd_idx  = (r_state == ST_TICK) ? r_idx : cidx;
    assign rd_cur  = r_cur[rd_idx];
    assign rd_tgt  = r_tgt[rd_idx];
    assign rd_step = r_step[rd_idx];

    // Shared slew unit; during a test tick the position starts from the sweep.
    t_slew_req slew_req;
    t_pos      slew_next;

    assign slew_req.cur  = r_tick_test ? r_sweep_snap : rd_cur;
    assign slew_req.tgt  = rd_tgt;
    assign slew_req.step = rd_step;

    sslim_slew_unit u_slew (
        .i_req  (slew_req),
        .o_next (slew_next)
    );

    // -------------------------------------------------------------------------
    // Command update for the addressed channel
    // -------------------------------------------------------------------------
    t_pos  counts;
    t_pos  cmd_cur;
    t_pos  cmd_tgt;
    t_step cmd_step;
    t_pos  cmd_pos;

    assign counts = to_counts(r_prom);

    always_comb begin
        cmd_cur  = rd_cur;
        cmd_tgt  = rd_tgt;
        cmd_step = rd_step;
        case (r_func)
            FUNC_SET: begin
                cmd_tgt = counts;
                if (r_speed == '0) begin
                    cmd_cur = counts;
                end else begin
                    cmd_step = r_speed;
                end
            end
            FUNC_POS: begin
                cmd_tgt = counts;
                if (rd_step == '0) begin
                    cmd_cur = counts;
                end
            end
            FUNC_STEP: begin
                cmd_step = r_speed;
            end
            default: begin
            end
        endcase
        cmd_pos = ch_ok ? cmd_cur : '0;
    end

    // sweep: turn at the limits, then move by one delta
    always_comb begin
        n_sweep_rising = r_sweep_rising;
        if (r_sweep_level >= SWEEP_HIGH) begin
            n_sweep_rising = 1'b0;
        end
        if (r_sweep_level <= SWEEP_LOW) begin
            n_sweep_rising = 1'b1;
        end
        n_sweep_level = n_sweep_rising ? (r_sweep_level + SWEEP_DELTA)
                                       : (r_sweep_level - SWEEP_DELTA);
    end

    // -------------------------------------------------------------------------
    // Sequencer: next state
    // -------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.func == FUNC_TICK) begin
                        n_state = ST_TICK;
                    end else if (i_req.func inside {[FUNC_SET:FUNC_TEST]}) begin
                        n_state = ST_CMD;
                    end
                end
            end
            ST_TICK: begin
                if (do_tick && tick_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CMD: begin
                if (do_cmd) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        req_ready = 1'b0;
        do_tick   = 1'b0;
        do_cmd    = 1'b0;
        case (r_state)
            ST_IDLE: req_ready = 1'b1;
            ST_TICK: do_tick   = slot_free;
            ST_CMD:  do_cmd    = slot_free;
            default: begin
            end
        endcase
        tick_last = (r_idx == CW'(CHANNELS - 1));
    end

    assign i_req.ready = req_ready;

    // -------------------------------------------------------------------------
    // Control and state registers
    // -------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_idx          <= '0;
            r_test         <= 1'b0;
            r_sweep_level  <= HOME_COUNT;
            r_sweep_rising <= 1'b1;
            r_tick_test    <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cur[i]  <= HOME_COUNT;
                r_tgt[i]  <= HOME_COUNT;
                r_step[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (accept) begin
                r_idx <= '0;
                if (i_req.func == FUNC_TICK) begin
                    r_tick_test <= r_test;
                    if (r_test) begin
                        r_sweep_level  <= n_sweep_level;
                        r_sweep_rising <= n_sweep_rising;
                    end
                end else begin
                    r_tick_test <= 1'b0;
                    r_test      <= (i_req.func == FUNC_TEST);
                end
            end else if (do_tick) begin
                r_idx <= r_idx + 1'b1;
            end

            if (do_tick) begin
                r_cur[r_idx] <= slew_next;
            end
            if (do_cmd && ch_ok) begin
                r_cur[cidx]  <= cmd_cur;
                r_tgt[cidx]  <= cmd_tgt;
                r_step[cidx] <= cmd_step;
            end

            if (do_tick || do_cmd) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request latch and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func       <= i_req.func;
            r_ch         <= i_req.channel;
            r_prom       <= i_req.position_promille;
            r_speed      <= i_req.speed;
            r_sweep_snap <= r_sweep_level;
        end
        if (do_tick) begin
            r_kind    <= KIND_REPORT;
            r_out_ch  <= CH_W'(r_idx);
            r_out_pos <= slew_next;
            r_last    <= tick_last;
        end else if (do_cmd) begin
            r_kind    <= KIND_ACK;
            r_out_ch  <= r_ch;
            r_out_pos <= cmd_pos;
            r_last    <= 1'b1;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.kind        = r_kind;
    assign o_rsp.out_channel = r_out_ch;
    assign o_rsp.position    = r_out_pos;
    assign o_rsp.last        = r_last;

`ifndef ASSERT_OFF
    // an accepted tick starts its walk at channel zero
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.func == FUNC_TICK) |=> (r_state == ST_TICK && r_idx == '0))
        else $error("tick did not start at channel zero");

    // acknowledges are always the final result of their request
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind == KIND_ACK) |-> o_rsp.last)
        else $error("acknowledge without last");

    // a tick report carries last only for the final channel
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind == KIND_REPORT && o_rsp.last)
        |-> (o_rsp.out_channel == CH_W'(CHANNELS - 1)))
        else $error("report last on wrong channel");

    // sweep level never leaves its bounce band
    a_sweep_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sweep_level >= (SWEEP_LOW - SWEEP_DELTA))
        && (r_sweep_level <= (SWEEP_HIGH + SWEEP_DELTA)))
        else $error("sweep level out of band");

    // no new result is loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> (!do_tick && !do_cmd))
        else $error("result overwritten while stalled");
`endif

endmodule
